>>> src/dsra_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register indexes and pipeline payload types for the
// diffusion stencil row assembler. No dependencies.
package dsra_pkg;

  localparam int MAX_DIMS = 3;
  localparam int NLANES   = 2 * MAX_DIMS;

  localparam int IDX_W    = 30;
  localparam int COEF_W   = 24;
  localparam int VAL_W    = 30;
  localparam int GRID_W   = 10;
  localparam int DIMS_W   = 2;
  localparam int MASK_W   = NLANES;
  localparam int NSQ_W    = 2 * GRID_W;
  localparam int PROD_W   = 2 * COEF_W + 1;
  localparam int SUM_W    = COEF_W + 1;
  localparam int DIAG_W   = 28;
  localparam int SLOT_W   = 3;

  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 96;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = GRID_W;

  // coordinate split: long division of the index, then of its remainder
  localparam int DIV1_STEPS   = IDX_W;
  localparam int DIV2_STEPS   = GRID_W;
  localparam int COORD_STAGES = DIV1_STEPS + DIV2_STEPS;
  localparam int MEAN_STEPS   = COEF_W;
  localparam int MEAN_TAIL    = COORD_STAGES - MEAN_STEPS;
  localparam int FRONT_STAGES = 2;
  localparam int PIPE_DEPTH   = FRONT_STAGES + COORD_STAGES;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIMS          = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY_MASK = 2'd2;

  localparam logic [DIMS_W-1:0] DIMS_TWO   = 2'd2;
  localparam logic [DIMS_W-1:0] DIMS_THREE = 2'd3;

  typedef struct packed {
    logic [GRID_W-1:0] n;
    logic [DIMS_W-1:0] dims;
    logic [MASK_W-1:0] mask;
  } cfg_t;

  typedef struct packed {
    logic [IDX_W-1:0]                   idx;
    logic [COEF_W-1:0]                  center;
    logic [NLANES-1:0][COEF_W-1:0]      coeff;
    cfg_t                               cfg;
  } raw_t;

  typedef struct packed {
    logic [IDX_W-1:0]  idx;
    logic [COEF_W-1:0] center;
    cfg_t              cfg;
    logic [NSQ_W-1:0]  nsq;
  } side_t;

  typedef struct packed {
    side_t                         side;
    logic [NLANES-1:0][PROD_W-1:0] prod;
    logic [NLANES-1:0][SUM_W-1:0]  sum;
  } front_t;

  typedef struct packed {
    side_t             side;
    logic [IDX_W-1:0]  q1;
    logic [GRID_W-1:0] q2;
    logic [GRID_W-1:0] r2;
  } coord_t;

  typedef struct packed {
    logic take;
    logic busy;
  } emit_ctl_t;

endpackage

>>> src/diffusion_stencil_row_assembler.sv
`timescale 1ns / 1ps
// Top level of the diffusion stencil row assembler: configuration registers,
// pipeline valid chain and the front, divider and emitter stages. Uses dsra_pkg.
//
// Each beat on the input carries one grid cell; the block returns its sparse
// matrix row as (row, column, value) beats, lower then upper neighbor per
// dimension and the diagonal last with tlast set. A cell can enter the pipeline
// every cycle until the pipeline backs up behind the emitter; the cell passes
// through the front multipliers and the one-bit-per-stage coordinate and mean
// dividers, then the emitter walks its 2*dims+1 slots, one slot per cycle while
// the output is not stalled, skipped boundary slots included. The emitter
// therefore sets the sustained rate. Configuration is sampled with each cell
// as it enters, so writes take effect for the next beat.
module diffusion_stencil_row_assembler
  import dsra_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // cell_index, center_coeff, coeff_down_x, coeff_up_x, coeff_down_y,
  // coeff_up_y, coeff_down_z, coeff_up_z
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // row, column, value
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  logic [GRID_W-1:0]     grid_r;
  logic [DIMS_W-1:0]     dims_r;
  logic [MASK_W-1:0]     mask_r;
  logic [PIPE_DEPTH-1:0] v_r;
  logic                  adv;
  raw_t                  raw;
  front_t                front;
  coord_t                coord;
  logic [NLANES-1:0][COEF_W-1:0] mean;
  emit_ctl_t             ctl;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_r <= GRID_W'(8);
      dims_r <= DIMS_TWO;
      mask_r <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GRID_SIZE:     grid_r <= cfg_data;
        REG_DIMS:          dims_r <= cfg_data[DIMS_W-1:0];
        REG_BOUNDARY_MASK: mask_r <= cfg_data[MASK_W-1:0];
        default:           ;
      endcase
    end
  end

  always_comb begin
    raw.idx    = in_tdata[IDX_W-1:0];
    raw.center = in_tdata[IDX_W +: COEF_W];
    for (int i = 0; i < NLANES; i++) begin
      raw.coeff[i] = in_tdata[IDX_W + COEF_W * (i + 1) +: COEF_W];
    end
    raw.cfg.n    = (grid_r == '0) ? GRID_W'(1) : grid_r;
    raw.cfg.dims = dims_r;
    raw.cfg.mask = mask_r;
  end

  // global advance: hold every stage while the last one waits on the emitter
  assign adv       = !v_r[PIPE_DEPTH-1] || ctl.take;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[PIPE_DEPTH-2:0], in_tvalid};
    end
  end

  dsra_front u_front (
    .clk   (clk),
    .adv   (adv),
    .raw   (raw),
    .front (front)
  );

  dsra_coord u_coord (
    .clk   (clk),
    .adv   (adv),
    .front (front),
    .coord (coord)
  );

  dsra_mean u_mean (
    .clk   (clk),
    .adv   (adv),
    .front (front),
    .mean  (mean)
  );

  dsra_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (v_r[PIPE_DEPTH-1]),
    .item       (coord),
    .item_mean  (mean),
    .ctl        (ctl),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

>>> src/dsra_front.sv
`timescale 1ns / 1ps
// Front stages: capture the beat with its configuration, then form the
// harmonic-mean products and sums and the squared grid size. Uses dsra_pkg.
module dsra_front
  import dsra_pkg::*;
(
  input  logic   clk,
  input  logic   adv,
  input  raw_t   raw,
  output front_t front
);

  raw_t   f0_r;
  front_t f1_r;
  front_t f1_nxt;

  always_comb begin
    f1_nxt.side.idx    = f0_r.idx;
    f1_nxt.side.center = f0_r.center;
    f1_nxt.side.cfg    = f0_r.cfg;
    f1_nxt.side.nsq    = NSQ_W'(f0_r.cfg.n) * NSQ_W'(f0_r.cfg.n);
    for (int i = 0; i < NLANES; i++) begin
      f1_nxt.prod[i] = {(2 * COEF_W)'(f0_r.center) * (2 * COEF_W)'(f0_r.coeff[i]), 1'b0};
      f1_nxt.sum[i]  = SUM_W'(f0_r.center) + SUM_W'(f0_r.coeff[i]);
      // both zero: product is zero, so any nonzero divisor yields zero
      if (f1_nxt.sum[i] == '0) begin
        f1_nxt.sum[i] = SUM_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f0_r <= raw;
      f1_r <= f1_nxt;
    end
  end

  assign front = f1_r;

endmodule

>>> src/dsra_coord.sv
`timescale 1ns / 1ps
// Pipelined restoring divider that splits the cell index into coordinates,
// one quotient bit per stage; carries the cell sideband. Uses dsra_pkg.
module dsra_coord
  import dsra_pkg::*;
(
  input  logic   clk,
  input  logic   adv,
  input  front_t front,
  output coord_t coord
);

  typedef struct packed {
    side_t             side;
    logic [NSQ_W-1:0]  d1;
    logic [GRID_W-1:0] d2;
    logic [NSQ_W-1:0]  r1;
    logic [IDX_W-1:0]  q1;
    logic [GRID_W-1:0] r2;
    logic [GRID_W-1:0] s2;
  } cstage_t;

  cstage_t stg_r [COORD_STAGES];
  cstage_t init;

  always_comb begin
    init      = '0;
    init.side = front.side;
    unique case (front.side.cfg.dims)
      DIMS_THREE: begin
        init.d1 = front.side.nsq;
        init.d2 = front.side.cfg.n;
      end
      DIMS_TWO: begin
        init.d1 = NSQ_W'(front.side.cfg.n);
        init.d2 = GRID_W'(1);
      end
      default: begin
        init.d1 = NSQ_W'(1);
        init.d2 = GRID_W'(1);
      end
    endcase
  end

  for (genvar k = 0; k < COORD_STAGES; k++) begin : g_stage
    cstage_t prev;
    cstage_t stg_nxt;

    if (k == 0) begin : g_first
      assign prev = init;
    end else begin : g_next
      assign prev = stg_r[k-1];
    end

    if (k < DIV1_STEPS) begin : g_div1
      always_comb begin
        logic [NSQ_W:0] t;
        t       = {prev.r1, prev.side.idx[IDX_W-1-k]};
        stg_nxt = prev;
        if (t >= {1'b0, prev.d1}) begin
          stg_nxt.r1 = NSQ_W'(t - {1'b0, prev.d1});
          stg_nxt.q1 = {prev.q1[IDX_W-2:0], 1'b1};
        end else begin
          stg_nxt.r1 = t[NSQ_W-1:0];
          stg_nxt.q1 = {prev.q1[IDX_W-2:0], 1'b0};
        end
      end
    end else begin : g_div2
      always_comb begin
        logic [GRID_W-1:0] rs;
        logic [GRID_W-1:0] ss;
        logic [GRID_W:0]   t;
        // first step of the second division loads the remainder of the first
        if (k == DIV1_STEPS) begin
          rs = prev.r1[NSQ_W-1:GRID_W];
          ss = prev.r1[GRID_W-1:0];
        end else begin
          rs = prev.r2;
          ss = prev.s2;
        end
        t       = {rs, ss[GRID_W-1]};
        stg_nxt = prev;
        if (t >= {1'b0, prev.d2}) begin
          stg_nxt.r2 = GRID_W'(t - {1'b0, prev.d2});
          stg_nxt.s2 = {ss[GRID_W-2:0], 1'b1};
        end else begin
          stg_nxt.r2 = t[GRID_W-1:0];
          stg_nxt.s2 = {ss[GRID_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg_r[k] <= stg_nxt;
      end
    end
  end

  assign coord.side = stg_r[COORD_STAGES-1].side;
  assign coord.q1   = stg_r[COORD_STAGES-1].q1;
  assign coord.q2   = stg_r[COORD_STAGES-1].s2;
  assign coord.r2   = stg_r[COORD_STAGES-1].r2;

endmodule

>>> src/dsra_mean.sv
`timescale 1ns / 1ps
// Six-lane pipelined divider for the harmonic means 2ab/(a+b), one quotient
// bit per stage, then delay stages to line up with dsra_coord. Uses dsra_pkg.
module dsra_mean
  import dsra_pkg::*;
(
  input  logic                          clk,
  input  logic                          adv,
  input  front_t                        front,
  output logic [NLANES-1:0][COEF_W-1:0] mean
);

  typedef struct packed {
    logic [SUM_W-1:0]  r;
    logic [COEF_W-1:0] pq;
    logic [SUM_W-1:0]  s;
  } mlane_t;

  typedef mlane_t [NLANES-1:0] mstage_t;
  typedef logic [NLANES-1:0][COEF_W-1:0] means_t;

  mstage_t stg_r  [MEAN_STEPS];
  means_t  tail_r [MEAN_TAIL];
  mstage_t init;

  always_comb begin
    for (int i = 0; i < NLANES; i++) begin
      init[i].r  = front.prod[i][PROD_W-1:COEF_W];
      init[i].pq = front.prod[i][COEF_W-1:0];
      init[i].s  = front.sum[i];
    end
  end

  for (genvar k = 0; k < MEAN_STEPS; k++) begin : g_stage
    mstage_t prev;
    mstage_t stg_nxt;

    if (k == 0) begin : g_first
      assign prev = init;
    end else begin : g_next
      assign prev = stg_r[k-1];
    end

    always_comb begin
      logic [SUM_W:0] t;
      for (int i = 0; i < NLANES; i++) begin
        t               = {prev[i].r, prev[i].pq[COEF_W-1]};
        stg_nxt[i].s    = prev[i].s;
        if (t >= {1'b0, prev[i].s}) begin
          stg_nxt[i].r  = SUM_W'(t - {1'b0, prev[i].s});
          stg_nxt[i].pq = {prev[i].pq[COEF_W-2:0], 1'b1};
        end else begin
          stg_nxt[i].r  = t[SUM_W-1:0];
          stg_nxt[i].pq = {prev[i].pq[COEF_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        stg_r[k] <= stg_nxt;
      end
    end
  end

  for (genvar k = 0; k < MEAN_TAIL; k++) begin : g_tail
    means_t tail_nxt;
    if (k == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < NLANES; i++) begin
          tail_nxt[i] = stg_r[MEAN_STEPS-1][i].pq;
        end
      end
    end else begin : g_next
      assign tail_nxt = tail_r[k-1];
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        tail_r[k] <= tail_nxt;
      end
    end
  end

  assign mean = tail_r[MEAN_TAIL-1];

endmodule

>>> src/dsra_emit.sv
`timescale 1ns / 1ps
// Entry sequencer: walks the face slots of one cell, one matrix entry per
// beat into the output register, diagonal last. Uses dsra_pkg.
module dsra_emit
  import dsra_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          item_valid,
  input  coord_t                        item,
  input  logic [NLANES-1:0][COEF_W-1:0] item_mean,
  output emit_ctl_t                     ctl,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_DATA_W-1:0]         out_tdata,
  output logic                          out_tlast
);

  logic                                  busy_r, busy_nxt;
  logic [SLOT_W-1:0]                     slot_r, slot_nxt;
  logic [DIAG_W-1:0]                     acc_r, acc_nxt;
  side_t                                 side_r;
  logic [MAX_DIMS-1:0][IDX_W-1:0]        crd_r, crd_nxt;
  logic [NLANES-1:0][COEF_W-1:0]         mean_r;

  logic                                  ov_r, ov_nxt;
  logic [IDX_W-1:0]                      orow_r, ocol_r, ocol_nxt;
  logic [VAL_W-1:0]                      oval_r, oval_nxt;
  logic                                  olast_r, olast_nxt;

  logic                                  step, diag, hi, exists, take;
  logic [1:0]                            dim;
  logic [IDX_W-1:0]                      c, stride;
  logic [COEF_W-1:0]                     m;

  assign step = busy_r && (!ov_r || out_tready);
  assign diag = (slot_r == {side_r.cfg.dims, 1'b0});
  assign dim  = slot_r[SLOT_W-1:1];
  assign hi   = slot_r[0];
  assign m    = mean_r[slot_r];
  assign take = item_valid && (!busy_r || (step && diag));

  always_comb begin
    unique case (dim)
      2'd1:    begin c = crd_r[1]; stride = IDX_W'(side_r.cfg.n); end
      2'd2:    begin c = crd_r[2]; stride = IDX_W'(side_r.nsq);   end
      default: begin c = crd_r[0]; stride = IDX_W'(1);            end
    endcase
    if (hi) begin
      exists = c < (IDX_W'(side_r.cfg.n) - IDX_W'(1));
    end else begin
      exists = (c != '0);
    end
  end

  // coordinates from the two quotients and the final remainder
  always_comb begin
    crd_nxt = '0;
    unique case (item.side.cfg.dims)
      DIMS_THREE: begin
        crd_nxt[0] = IDX_W'(item.r2);
        crd_nxt[1] = IDX_W'(item.q2);
        crd_nxt[2] = item.q1;
      end
      DIMS_TWO: begin
        crd_nxt[0] = IDX_W'(item.q2);
        crd_nxt[1] = item.q1;
      end
      default: begin
        crd_nxt[0] = item.q1;
      end
    endcase
  end

  always_comb begin
    busy_nxt  = busy_r;
    slot_nxt  = slot_r;
    acc_nxt   = acc_r;
    ov_nxt    = ov_r && !out_tready;
    ocol_nxt  = ocol_r;
    oval_nxt  = oval_r;
    olast_nxt = olast_r;
    if (step) begin
      if (diag) begin
        busy_nxt  = 1'b0;
        ov_nxt    = 1'b1;
        ocol_nxt  = side_r.idx;
        oval_nxt  = VAL_W'(acc_r);
        olast_nxt = 1'b1;
      end else begin
        slot_nxt = slot_r + SLOT_W'(1);
        if (exists) begin
          ov_nxt    = 1'b1;
          ocol_nxt  = hi ? side_r.idx + stride : side_r.idx - stride;
          oval_nxt  = VAL_W'(0) - VAL_W'(m);
          olast_nxt = 1'b0;
          acc_nxt   = acc_r + DIAG_W'(m);
        end else if (side_r.cfg.mask[slot_r]) begin
          // Dirichlet face adds twice the center coefficient
          acc_nxt = acc_r + DIAG_W'({side_r.center, 1'b0});
        end
      end
    end
    if (take) begin
      busy_nxt = 1'b1;
      slot_nxt = '0;
      acc_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r  <= slot_nxt;
    acc_r   <= acc_nxt;
    ocol_r  <= ocol_nxt;
    oval_r  <= oval_nxt;
    olast_r <= olast_nxt;
    if (step) begin
      orow_r <= side_r.idx;
    end
    if (take) begin
      side_r <= item.side;
      crd_r  <= crd_nxt;
      mean_r <= item_mean;
    end
  end

  assign ctl.take   = take;
  assign ctl.busy   = busy_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = {(OUT_DATA_W - 2 * IDX_W - VAL_W)'(0), oval_r, ocol_r, orow_r};
  assign out_tlast  = olast_r;

endmodule

>>> src/dsra_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the row assembler, bound to the top level.
// Uses dsra_pkg.
module dsra_checker
  import dsra_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output beat changed while stalled");

  a_diag_column: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[2*IDX_W-1:IDX_W] == out_tdata[IDX_W-1:0])
    else $error("diagonal beat column differs from row");

  a_offdiag_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |->
      out_tdata[2*IDX_W+VAL_W-1] || out_tdata[2*IDX_W+VAL_W-1:2*IDX_W] == '0)
    else $error("neighbor entry is positive");

  a_diag_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tdata[2*IDX_W+VAL_W-1])
    else $error("diagonal entry is negative");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind diffusion_stencil_row_assembler dsra_checker u_dsra_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

>>> tb/sv/diffusion_stencil_row_assembler_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for diffusion_stencil_row_assembler: predicts the
// sparse matrix row of each cell and compares every output beat. Uses dsra_pkg.
module diffusion_stencil_row_assembler_tb;
  import dsra_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] column;
    logic [VAL_W-1:0] value;
    logic             last;
  } entry_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  logic [GRID_W-1:0] grid_n;
  logic [DIMS_W-1:0] dim_cnt;
  logic [MASK_W-1:0] dirichlet;

  entry_t row_entries_q[$];
  int     errors;
  bit     stall_on;

  diffusion_stencil_row_assembler dut (.*);

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  function automatic logic [63:0] harm_mean(logic [63:0] a, logic [63:0] b);
    if (a == 0 || b == 0) return 64'd0;
    return (2 * a * b) / (a + b);
  endfunction

  // append one expected entry at the tail
  task automatic queue_entry(entry_t e);
    row_entries_q = {row_entries_q, e};
  endtask

  // Expand one cell into its matrix entries, diagonal last.
  task automatic predict_row(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] ctr,
                             logic [NLANES-1:0][COEF_W-1:0] nb);
    logic [63:0] n, rem, m, diag;
    logic [63:0] stride[3];
    logic [63:0] coord[3];
    int d;
    entry_t e;
    n = (grid_n == 0) ? 64'd1 : 64'(grid_n);
    d = (dim_cnt > MAX_DIMS) ? MAX_DIMS : int'(dim_cnt);
    stride[0] = 1; stride[1] = n; stride[2] = n * n;
    coord[0] = 0; coord[1] = 0; coord[2] = 0;
    rem = idx;
    diag = 0;
    for (int i = d - 1; i >= 0; i--) begin
      coord[i] = rem / stride[i];
      rem = rem % stride[i];
    end
    for (int i = 0; i < d; i++) begin
      if (coord[i] > 0) begin
        m = harm_mean(ctr, nb[2*i]);
        e.row = idx; e.column = IDX_W'(idx - stride[i]);
        e.value = VAL_W'(-m); e.last = 1'b0;
        queue_entry(e);
        diag += m;
      end else if (dirichlet[2*i]) begin
        diag += 2 * ctr;
      end
      if (coord[i] < n - 1) begin
        m = harm_mean(ctr, nb[2*i+1]);
        e.row = idx; e.column = IDX_W'(idx + stride[i]);
        e.value = VAL_W'(-m); e.last = 1'b0;
        queue_entry(e);
        diag += m;
      end else if (dirichlet[2*i+1]) begin
        diag += 2 * ctr;
      end
    end
    e.row = idx; e.column = idx; e.value = VAL_W'(diag); e.last = 1'b1;
    queue_entry(e);
  endtask

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return;
    in_tvalid <= 1'b0;
    repeat ((r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40)) @(posedge clk);
  endtask

  // valid stays high after the handshake; the next caller drives it
  task automatic send_cell(logic [IDX_W-1:0] idx, logic [COEF_W-1:0] ctr,
                           logic [NLANES-1:0][COEF_W-1:0] nb);
    predict_row(idx, ctr, nb);
    in_tdata  <= {2'd0, nb, ctr, idx};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (row_entries_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    // the pipeline is about 42 deep
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    case (idx)
      REG_GRID_SIZE:     grid_n = v;
      REG_DIMS:          dim_cnt = v[DIMS_W-1:0];
      REG_BOUNDARY_MASK: dirichlet = v[MASK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic setup(int n, int d, int mask);
    drain();
    write_reg(REG_GRID_SIZE, CFG_DATA_W'(n));
    write_reg(REG_DIMS, CFG_DATA_W'(d));
    write_reg(REG_BOUNDARY_MASK, CFG_DATA_W'(mask));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [COEF_W-1:0] rand_coeff();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return COEF_W'($urandom_range(1, 255));
      default: return COEF_W'($urandom);
    endcase
  endfunction

  task automatic send_random(int cnt, int span);
    logic [NLANES-1:0][COEF_W-1:0] nb;
    logic [IDX_W-1:0] idx;
    for (int k = 0; k < cnt; k++) begin
      for (int j = 0; j < NLANES; j++) nb[j] = rand_coeff();
      idx = ($urandom_range(0, 9) == 0) ? IDX_W'($urandom) : IDX_W'($urandom_range(0, span));
      send_cell(idx, rand_coeff(), nb);
      idle_gap();
    end
  endtask

  task automatic test_directed();
    logic [NLANES-1:0][COEF_W-1:0] nb;
    setup(4, 3, 63);
    for (int j = 0; j < NLANES; j++) nb[j] = COEF_W'(j * 100 + 1);
    send_cell(0, 24'h010000, nb);           // corner, lower faces on the boundary
    send_cell(63, 24'hFFFFFF, '1);          // opposite corner, max coeffs
    send_cell(21, 24'h020000, nb);          // interior
    send_cell(21, 0, nb);                   // zero centre gives zero means
    send_cell(21, 24'h010000, '0);          // zero neighbors
    send_cell(IDX_W'('1), 24'h123456, nb);  // index past the grid
    send_cell(100, 24'h00ABCD, nb);         // top coordinate beyond grid
    setup(0, 0, 0);                         // grid zero, no dimensions
    send_cell(5, 24'hFFFFFF, nb);
    send_cell(0, 24'h000001, '1);
    setup(1023, 1, 21);
    send_cell(0, 24'h008000, nb);
    send_cell(1022, 24'h008000, nb);
    send_cell(500, 24'hFFFFFF, '1);
    setup(1, 2, 42);
    send_cell(0, 24'h010000, nb);
    send_cell(3, 24'h010000, nb);
  endtask

  task automatic test_random_configs();
    int gsz;
    for (int p = 0; p < 6; p++) begin
      gsz = (p == 5) ? 1023 : $urandom_range(1, 12);
      setup(gsz, $urandom_range(0, 3), $urandom_range(0, 63));
      stall_on = (p != 2);
      send_random(22, gsz * gsz * gsz + gsz);
    end
    stall_on = 1'b1;
  endtask

  // sender pauses for a full drain in the middle of the stream
  task automatic test_drain_pause();
    setup(8, 2, 63);
    send_random(8, 80);
    in_tvalid <= 1'b0;
    while (row_entries_q.size() != 0) @(posedge clk);
    send_random(8, 80);
  endtask

  always @(posedge clk) begin
    entry_t got, exp;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[IDX_W-1:0], out_tdata[2*IDX_W-1:IDX_W],
             out_tdata[2*IDX_W+VAL_W-1:2*IDX_W], out_tlast};
      if (row_entries_q.size() == 0) begin
        $display("%0t unexpected beat: actual %h", $time, got);
        errors++;
      end else begin
        exp = row_entries_q.pop_front();
        if (got.row !== exp.row) begin
          $display("%0t row: expected %h actual %h", $time, exp.row, got.row);
          errors++;
        end
        if (got.column !== exp.column) begin
          $display("%0t column: expected %h actual %h", $time, exp.column, got.column);
          errors++;
        end
        if (got.value !== exp.value) begin
          $display("%0t value: expected %h actual %h", $time, exp.value, got.value);
          errors++;
        end
        if (got.last !== exp.last) begin
          $display("%0t last: expected %b actual %b", $time, exp.last, got.last);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (!stall_on) out_tready <= 1'b1;
    else if (r < 70) out_tready <= 1'b1;
    else if (r < 97) out_tready <= 1'b0;
    else out_tready <= ($urandom_range(0, 1) == 1);
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    errors = 0;
    stall_on = 1'b1;
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_tvalid = 1'b0; in_tdata = '0;
    grid_n = 8; dim_cnt = 2; dirichlet = 63;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_random(4, 63);   // reset configuration
    test_directed();
    test_drain_pause();
    test_random_configs();
    drain();
    if (row_entries_q.size() != 0) begin
      $display("%0t %0d entries never arrived", $time, row_entries_q.size());
      errors++;
    end
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
